FILE: hdl/cio_pkg.sv
// Shared types and constants for the console I/O port register bank.
// Used by cio_access and console_io_port_block_top; no other dependencies.
`default_nettype none

package cio_pkg;

  // Console model codes
  localparam logic [1:0] MODEL_MONO    = 2'd0;
  localparam logic [1:0] MODEL_POCKET  = 2'd1;
  localparam logic [1:0] MODEL_COLOR   = 2'd2;
  localparam logic [1:0] MODEL_CRYSTAL = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CONSOLE_MODEL        = 1'b0;
  localparam logic CFG_VERTICAL_ORIENTATION = 1'b1;

  // Access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Port addresses
  localparam logic [15:0] PORT_DMA_SRC_LO  = 16'h0040;
  localparam logic [15:0] PORT_DMA_SRC_MID = 16'h0041;
  localparam logic [15:0] PORT_DMA_SRC_HI  = 16'h0042;
  localparam logic [15:0] PORT_DMA_DST_LO  = 16'h0044;
  localparam logic [15:0] PORT_DMA_DST_HI  = 16'h0045;
  localparam logic [15:0] PORT_DMA_LEN_LO  = 16'h0046;
  localparam logic [15:0] PORT_DMA_LEN_HI  = 16'h0047;
  localparam logic [15:0] PORT_DMA_CTRL    = 16'h0048;
  localparam logic [15:0] PORT_SYSTEM      = 16'h0062;
  localparam logic [15:0] PORT_HW_FLAGS    = 16'h00a0;
  localparam logic [15:0] PORT_INT_BASE    = 16'h00b0;
  localparam logic [15:0] PORT_SER_DATA    = 16'h00b1;
  localparam logic [15:0] PORT_INT_ENABLE  = 16'h00b2;
  localparam logic [15:0] PORT_SER_STATUS  = 16'h00b3;
  localparam logic [15:0] PORT_INT_STATUS  = 16'h00b4;
  localparam logic [15:0] PORT_KEYPAD      = 16'h00b5;
  localparam logic [15:0] PORT_INT_ACK     = 16'h00b6;

  // Fixed masks and values
  localparam logic [7:0] INT_ACK_MASK      = 8'b1111_0010;
  localparam logic [7:0] HW_FLAGS_BASE     = 8'h85;
  localparam logic [7:0] INT_BASE_MASK_MONO  = 8'hf8;
  localparam logic [7:0] INT_BASE_MASK_COLOR = 8'hfe;

  // Architectural register state of the bank
  typedef struct packed {
    logic [19:0] dma_source;
    logic [15:0] dma_target;
    logic [15:0] dma_length;
    logic        dma_mode;
    logic        dma_enable;
    logic [7:0]  irq_vector_base;
    logic [7:0]  serial_byte;
    logic [7:0]  irq_mask;
    logic [7:0]  irq_pending;
    logic        serial_baud;
    logic        serial_enable;
    logic [2:0]  keypad_select;
  } bank_state_t;

  // Configuration registers
  typedef struct packed {
    logic [1:0] console_model;
    logic       vertical;
  } bank_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/cio_access.sv
// Port access decode: next register state and result byte for one access.
// Pure combinational; depends on cio_pkg.
`default_nettype none

module cio_access (
  input  var cio_pkg::bank_state_t cur,
  input  var cio_pkg::bank_cfg_t   cfg,
  input  wire logic                action,
  input  wire logic [15:0]         port_address,
  input  wire logic [7:0]          write_data,
  input  wire logic [10:0]         pad_lines,
  input  wire logic [7:0]          interrupt_raise,
  output cio_pkg::bank_state_t     nxt,
  output logic [7:0]               read_data,
  output logic                     dma_start
);

  logic       mono_class;
  logic [3:0] pad_y;
  logic [3:0] pad_x;
  logic [3:0] keys;
  logic [7:0] status_raised;

  assign mono_class = (cfg.console_model == cio_pkg::MODEL_MONO) ||
                      (cfg.console_model == cio_pkg::MODEL_POCKET);
  assign pad_y = pad_lines[3:0];
  assign pad_x = pad_lines[7:4];
  assign status_raised = cur.irq_pending | interrupt_raise;

  // Keypad matrix mux; x select overrides y, buttons override bits 1-3
  always_comb begin
    keys = 4'd0;
    if (cur.keypad_select[0]) begin
      keys = cfg.vertical ? {pad_x[2:0], pad_x[3]} : pad_y;
    end
    if (cur.keypad_select[1]) begin
      keys = cfg.vertical ? {pad_y[2:0], pad_y[3]} : pad_x;
    end
    if (cur.keypad_select[2]) begin
      keys = {pad_lines[10:8], keys[0]};
    end
  end

  // Register update and read mux
  always_comb begin
    nxt = cur;
    nxt.irq_pending = status_raised;
    read_data = 8'd0;
    dma_start = 1'b0;
    if (action == cio_pkg::ACT_WRITE) begin
      case (port_address)
        cio_pkg::PORT_DMA_SRC_LO:  nxt.dma_source[7:0]   = {write_data[7:1], 1'b0};
        cio_pkg::PORT_DMA_SRC_MID: nxt.dma_source[15:8]  = write_data;
        cio_pkg::PORT_DMA_SRC_HI:  nxt.dma_source[19:16] = write_data[3:0];
        cio_pkg::PORT_DMA_DST_LO:  nxt.dma_target[7:0]   = {write_data[7:1], 1'b0};
        cio_pkg::PORT_DMA_DST_HI:  nxt.dma_target[15:8]  = write_data;
        cio_pkg::PORT_DMA_LEN_LO:  nxt.dma_length[7:0]   = {write_data[7:1], 1'b0};
        cio_pkg::PORT_DMA_LEN_HI:  nxt.dma_length[15:8]  = write_data;
        cio_pkg::PORT_DMA_CTRL: begin
          nxt.dma_mode   = write_data[6];
          nxt.dma_enable = write_data[7];
          dma_start      = write_data[7];
        end
        cio_pkg::PORT_INT_BASE: begin
          nxt.irq_vector_base = write_data & (mono_class ? cio_pkg::INT_BASE_MASK_MONO
                                                         : cio_pkg::INT_BASE_MASK_COLOR);
        end
        cio_pkg::PORT_SER_DATA: nxt.serial_byte = write_data;
        cio_pkg::PORT_INT_ENABLE: begin
          nxt.irq_mask    = write_data;
          nxt.irq_pending = status_raised & ~write_data;
        end
        cio_pkg::PORT_SER_STATUS: begin
          nxt.serial_baud   = write_data[6];
          nxt.serial_enable = write_data[7];
        end
        cio_pkg::PORT_KEYPAD: nxt.keypad_select = write_data[6:4];
        cio_pkg::PORT_INT_ACK: begin
          nxt.irq_pending = status_raised & ~(write_data & cio_pkg::INT_ACK_MASK);
        end
        default: ;
      endcase
    end else begin
      case (port_address)
        cio_pkg::PORT_DMA_SRC_LO:  read_data = cur.dma_source[7:0];
        cio_pkg::PORT_DMA_SRC_MID: read_data = cur.dma_source[15:8];
        cio_pkg::PORT_DMA_SRC_HI:  read_data = {4'd0, cur.dma_source[19:16]};
        cio_pkg::PORT_DMA_DST_LO:  read_data = cur.dma_target[7:0];
        cio_pkg::PORT_DMA_DST_HI:  read_data = cur.dma_target[15:8];
        cio_pkg::PORT_DMA_LEN_LO:  read_data = cur.dma_length[7:0];
        cio_pkg::PORT_DMA_LEN_HI:  read_data = cur.dma_length[15:8];
        cio_pkg::PORT_DMA_CTRL:    read_data = {cur.dma_enable, 6'd0, cur.dma_mode};
        cio_pkg::PORT_SYSTEM: begin
          read_data = {(cfg.console_model == cio_pkg::MODEL_CRYSTAL), 7'd0};
        end
        cio_pkg::PORT_HW_FLAGS: begin
          read_data = cio_pkg::HW_FLAGS_BASE | {6'd0, ~mono_class, 1'b0};
        end
        cio_pkg::PORT_INT_BASE: begin
          read_data = cur.irq_vector_base | {6'd0, {2{mono_class}}};
        end
        cio_pkg::PORT_SER_DATA:    read_data = cur.serial_byte;
        cio_pkg::PORT_INT_ENABLE:  read_data = cur.irq_mask;
        cio_pkg::PORT_SER_STATUS: begin
          read_data = {cur.serial_enable, cur.serial_baud, 3'd0, 1'b1, 2'd0};
        end
        cio_pkg::PORT_INT_STATUS:  read_data = status_raised;
        cio_pkg::PORT_KEYPAD:      read_data = {1'b0, cur.keypad_select, keys};
        default:                   read_data = 8'd0;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/console_io_port_block_top.sv
// Console I/O port register bank: bank registers, config and result register.
// Depends on cio_pkg and cio_access.
//
// Each transfer on the input channel is one port read or write. Decode and
// register update happen in the cycle of the transfer, so the next access
// sees the new register values; the result is held in an output register. One
// access is taken every cycle: the input is ready whenever the result register
// is empty or is being drained in the same cycle, so a stall on the output
// only holds off the input while a result is waiting. Result valid rises in
// the cycle after the input transfer. Configuration writes take effect on the
// next access.
`default_nettype none

module console_io_port_block_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  // access input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [15:0] port_address,
  input  wire logic [7:0]  write_data,
  input  wire logic [10:0] pad_lines,
  input  wire logic [7:0]  interrupt_raise,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             dma_start,
  output logic [7:0]       pending_interrupts
);

  cio_pkg::bank_state_t bank;
  cio_pkg::bank_state_t bank_next;
  cio_pkg::bank_cfg_t   cfg;
  logic [7:0]           rd_next;
  logic                 start_next;
  logic                 in_xfer;

  assign in_ready = ~out_valid | out_ready;
  assign in_xfer  = in_valid & in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        cio_pkg::CFG_CONSOLE_MODEL:        cfg.console_model <= cfg_data;
        cio_pkg::CFG_VERTICAL_ORIENTATION: cfg.vertical      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cio_access u_access (
    .cur             (bank),
    .cfg             (cfg),
    .action          (action),
    .port_address    (port_address),
    .write_data      (write_data),
    .pad_lines       (pad_lines),
    .interrupt_raise (interrupt_raise),
    .nxt             (bank_next),
    .read_data       (rd_next),
    .dma_start       (start_next)
  );

  // Bank registers update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= '0;
    end else if (in_xfer) begin
      bank <= bank_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      read_data          <= rd_next;
      dma_start          <= start_next;
      pending_interrupts <= bank_next.irq_pending;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_console_io_port_block_top.sv
// Self-checking testbench for the console I/O port register bank.
// Depends on cio_pkg and console_io_port_block_top; keeps its own shadow of the
// bank, drives port accesses through valid/ready and checks every result.
module tb_console_io_port_block_top;

  timeunit 1ns;
  timeprecision 1ps;

  // One port access and the result it should produce
  typedef struct packed {
    logic        action;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [10:0] pad;
    logic [7:0]  raise;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       start;
    logic [7:0] irq;
  } bank_result_t;

  // Address that falls in the DMA block but maps to nothing
  localparam logic [15:0] PORT_UNMAPPED = 16'h0043;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = cio_pkg::CFG_CONSOLE_MODEL;
  logic [1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = cio_pkg::ACT_READ;
  logic [15:0] port_address = '0;
  logic [7:0]  write_data = '0;
  logic [10:0] pad_lines = '0;
  logic [7:0]  interrupt_raise = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        dma_start;
  logic [7:0]  pending_interrupts;

  // Shadow copy of the bank and its configuration
  cio_pkg::bank_state_t shadow = '0;
  cio_pkg::bank_cfg_t   shadow_cfg = '0;
  access_t      access_q[$];
  bank_result_t expected_q[$];

  int unsigned accesses_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned writes_seen = 0;
  int unsigned starts_seen = 0;
  int unsigned configs_used = 0;
  logic        in_xfer = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          send_idle_on = 1'b0;
  bit          recv_idle_on = 1'b0;
  int unsigned idle_pct = 15;

  logic [15:0] port_menu [19] = '{
    cio_pkg::PORT_DMA_SRC_LO, cio_pkg::PORT_DMA_SRC_MID, cio_pkg::PORT_DMA_SRC_HI,
    cio_pkg::PORT_DMA_DST_LO, cio_pkg::PORT_DMA_DST_HI, cio_pkg::PORT_DMA_LEN_LO,
    cio_pkg::PORT_DMA_LEN_HI, cio_pkg::PORT_DMA_CTRL, cio_pkg::PORT_SYSTEM,
    cio_pkg::PORT_HW_FLAGS, cio_pkg::PORT_INT_BASE, cio_pkg::PORT_SER_DATA,
    cio_pkg::PORT_INT_ENABLE, cio_pkg::PORT_SER_STATUS, cio_pkg::PORT_INT_STATUS,
    cio_pkg::PORT_KEYPAD, cio_pkg::PORT_INT_ACK, PORT_UNMAPPED,
    cio_pkg::PORT_KEYPAD
  };

  console_io_port_block_top DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .port_address       (port_address),
    .write_data         (write_data),
    .pad_lines          (pad_lines),
    .interrupt_raise    (interrupt_raise),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .read_data          (read_data),
    .dma_start          (dma_start),
    .pending_interrupts (pending_interrupts)
  );

  always #1 clk = ~clk;

  function automatic bit is_mono_class();
    return shadow_cfg.console_model == cio_pkg::MODEL_MONO ||
           shadow_cfg.console_model == cio_pkg::MODEL_POCKET;
  endfunction

  // Keypad matrix: x select overrides y, buttons override bits 1-3
  function automatic logic [3:0] keypad_lines(logic [10:0] pad);
    logic [3:0] y;
    logic [3:0] x;
    logic [3:0] d;
    y = pad[3:0];
    x = pad[7:4];
    d = '0;
    if (shadow.keypad_select[0]) d = shadow_cfg.vertical ? {x[2:0], x[3]} : y;
    if (shadow.keypad_select[1]) d = shadow_cfg.vertical ? {y[2:0], y[3]} : x;
    if (shadow.keypad_select[2]) d = {pad[10:8], d[0]};
    return d;
  endfunction

  // Apply one access to the shadow bank and return its result
  function automatic bank_result_t predict_access(access_t a);
    bank_result_t r;
    logic [7:0] d;
    r = '0;
    d = a.wdata;
    // raised status lands before the access itself
    shadow.irq_pending = shadow.irq_pending | a.raise;
    if (a.action == cio_pkg::ACT_WRITE) begin
      case (a.addr)
        cio_pkg::PORT_DMA_SRC_LO:  shadow.dma_source[7:0] = d & 8'hfe;
        cio_pkg::PORT_DMA_SRC_MID: shadow.dma_source[15:8] = d;
        cio_pkg::PORT_DMA_SRC_HI:  shadow.dma_source[19:16] = d[3:0];
        cio_pkg::PORT_DMA_DST_LO:  shadow.dma_target[7:0] = d & 8'hfe;
        cio_pkg::PORT_DMA_DST_HI:  shadow.dma_target[15:8] = d;
        cio_pkg::PORT_DMA_LEN_LO:  shadow.dma_length[7:0] = d & 8'hfe;
        cio_pkg::PORT_DMA_LEN_HI:  shadow.dma_length[15:8] = d;
        cio_pkg::PORT_DMA_CTRL: begin
          shadow.dma_mode = d[6];
          shadow.dma_enable = d[7];
          r.start = d[7];
        end
        cio_pkg::PORT_INT_BASE:
          shadow.irq_vector_base = d & (is_mono_class() ? cio_pkg::INT_BASE_MASK_MONO
                                                        : cio_pkg::INT_BASE_MASK_COLOR);
        cio_pkg::PORT_SER_DATA: shadow.serial_byte = d;
        cio_pkg::PORT_INT_ENABLE: begin
          shadow.irq_mask = d;
          shadow.irq_pending = shadow.irq_pending & ~d;
        end
        cio_pkg::PORT_SER_STATUS: begin
          shadow.serial_baud = d[6];
          shadow.serial_enable = d[7];
        end
        cio_pkg::PORT_KEYPAD:  shadow.keypad_select = d[6:4];
        cio_pkg::PORT_INT_ACK:
          shadow.irq_pending = shadow.irq_pending & ~(d & cio_pkg::INT_ACK_MASK);
        default: ;
      endcase
    end else begin
      case (a.addr)
        cio_pkg::PORT_DMA_SRC_LO:  r.rdata = shadow.dma_source[7:0];
        cio_pkg::PORT_DMA_SRC_MID: r.rdata = shadow.dma_source[15:8];
        cio_pkg::PORT_DMA_SRC_HI:  r.rdata = {4'b0, shadow.dma_source[19:16]};
        cio_pkg::PORT_DMA_DST_LO:  r.rdata = shadow.dma_target[7:0];
        cio_pkg::PORT_DMA_DST_HI:  r.rdata = shadow.dma_target[15:8];
        cio_pkg::PORT_DMA_LEN_LO:  r.rdata = shadow.dma_length[7:0];
        cio_pkg::PORT_DMA_LEN_HI:  r.rdata = shadow.dma_length[15:8];
        cio_pkg::PORT_DMA_CTRL:    r.rdata = {shadow.dma_enable, 6'b0, shadow.dma_mode};
        cio_pkg::PORT_SYSTEM:
          r.rdata = (shadow_cfg.console_model == cio_pkg::MODEL_CRYSTAL) ? 8'h80 : 8'h00;
        cio_pkg::PORT_HW_FLAGS:
          r.rdata = cio_pkg::HW_FLAGS_BASE | (is_mono_class() ? 8'h00 : 8'h02);
        cio_pkg::PORT_INT_BASE:
          r.rdata = shadow.irq_vector_base | (is_mono_class() ? 8'h03 : 8'h00);
        cio_pkg::PORT_SER_DATA:    r.rdata = shadow.serial_byte;
        cio_pkg::PORT_INT_ENABLE:  r.rdata = shadow.irq_mask;
        cio_pkg::PORT_SER_STATUS:
          r.rdata = {shadow.serial_enable, shadow.serial_baud, 6'b000100};
        cio_pkg::PORT_INT_STATUS:  r.rdata = shadow.irq_pending;
        cio_pkg::PORT_KEYPAD:
          r.rdata = {1'b0, shadow.keypad_select, keypad_lines(a.pad)};
        default:                   r.rdata = 8'h00;
      endcase
    end
    r.irq = shadow.irq_pending;
    return r;
  endfunction

  function automatic access_t mk(logic act, logic [15:0] addr, logic [7:0] d,
                                 logic [10:0] pad = '0, logic [7:0] raise = '0);
    access_t a;
    a.action = act;
    a.addr = addr;
    a.wdata = d;
    a.pad = pad;
    a.raise = raise;
    return a;
  endfunction

  task automatic queue_access(access_t a);
    access_q.push_back(a);
    accesses_queued++;
  endtask

  // Mostly mapped ports with random content, some fully random addresses
  task automatic queue_random(int unsigned n);
    access_t a;
    repeat (n) begin
      a.action = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85)
        a.addr = port_menu[$urandom_range(0, 18)];
      else
        a.addr = 16'($urandom_range(0, 65535));
      a.wdata = 8'($urandom_range(0, 255));
      a.pad = 11'($urandom_range(0, 2047));
      a.raise = ($urandom_range(0, 99) < 25) ? 8'($urandom_range(0, 255)) : 8'h00;
      queue_access(a);
    end
  endtask

  // Both registers, written only while the bank is idle
  task automatic set_config(logic [1:0] model, logic vert);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= cio_pkg::CFG_CONSOLE_MODEL;
    cfg_data <= model;
    @(negedge clk);
    cfg_index <= cio_pkg::CFG_VERTICAL_ORIENTATION;
    cfg_data <= {1'b0, vert};
    @(negedge clk);
    cfg_write_en <= 1'b0;
    shadow_cfg.console_model = model;
    shadow_cfg.vertical = vert;
    configs_used++;
  endtask

  // Every access gives one result, so the bank is idle once all have come back
  task automatic drain();
    while (results_seen < accesses_queued) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Input driver: new transfer or idle burst once the previous one is taken
  always @(negedge clk) begin
    access_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (send_idle_on && $urandom_range(0, 99) < idle_pct) begin
        send_gap <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        cur = access_q.pop_front();
        in_valid <= 1'b1;
        action <= cur.action;
        port_address <= cur.addr;
        write_data <= cur.wdata;
        pad_lines <= cur.pad;
        interrupt_raise <= cur.raise;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_on && $urandom_range(0, 99) < idle_pct) begin
      recv_gap <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    bank_result_t want;
    in_xfer <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      expected_q.push_back(predict_access(mk(action, port_address, write_data,
                                             pad_lines, interrupt_raise)));
      if (action == cio_pkg::ACT_WRITE) writes_seen++;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (dma_start) starts_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: read_data %0h dma_start %0b pending_interrupts %0h",
               read_data, dma_start, pending_interrupts);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (read_data !== want.rdata) begin
          $error("read_data: expected %02h, got %02h", want.rdata, read_data);
          fail_count++;
        end
        if (dma_start !== want.start) begin
          $error("dma_start: expected %0b, got %0b", want.start, dma_start);
          fail_count++;
        end
        if (pending_interrupts !== want.irq) begin
          $error("pending_interrupts: expected %02h, got %02h",
                 want.irq, pending_interrupts);
          fail_count++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    bank_result_t lost;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, alignment masks, DMA pulse, interrupts, keypad
    set_config(cio_pkg::MODEL_MONO, 1'b0);
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_SRC_LO, 8'hff));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_SRC_MID, 8'hff));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_SRC_HI, 8'hff));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_DMA_SRC_LO, 8'h00));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_DMA_SRC_HI, 8'hff));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_DST_LO, 8'h37));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_LEN_HI, 8'h80));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_DMA_DST_LO, 8'h00));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_CTRL, 8'hc0));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_DMA_CTRL, 8'h40));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_DMA_CTRL, 8'h00));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_SYSTEM, 8'h00));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_HW_FLAGS, 8'h00));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_INT_BASE, 8'hff));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_INT_BASE, 8'h00));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_SER_STATUS, 8'hff));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_SER_STATUS, 8'h00));
    // raise and clear in the same access
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_INT_STATUS, 8'h00, 11'h000, 8'hff));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_INT_ACK, 8'hff, 11'h000, 8'h01));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_INT_ENABLE, 8'h0f, 11'h000, 8'hff));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_KEYPAD, 8'h70));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_KEYPAD, 8'h00, 11'h7ff));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_KEYPAD, 8'h00, 11'h000));
    queue_access(mk(cio_pkg::ACT_READ, 16'hffff, 8'hff, 11'h7ff, 8'h00));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_HW_FLAGS, 8'hff));
    drain();

    // Random phases over several settings, with idling on both sides
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    set_config(cio_pkg::MODEL_CRYSTAL, 1'b1);
    // vertical keypad: y lines, x lines, buttons
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_KEYPAD, 8'h10));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_KEYPAD, 8'h00, 11'h5a9));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_KEYPAD, 8'h20));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_KEYPAD, 8'h00, 11'h2c6));
    queue_access(mk(cio_pkg::ACT_WRITE, cio_pkg::PORT_KEYPAD, 8'h50));
    queue_access(mk(cio_pkg::ACT_READ, cio_pkg::PORT_KEYPAD, 8'h00, 11'h3f1));
    queue_random(75);
    drain();

    idle_pct = 40;
    set_config(cio_pkg::MODEL_POCKET, 1'b1);
    queue_random(80);
    drain();

    idle_pct = 5;
    set_config(cio_pkg::MODEL_COLOR, 1'b0);
    queue_random(80);
    drain();

    idle_pct = 20;
    set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    queue_random(80);
    drain();

    // Last stretch at full rate
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    set_config(cio_pkg::MODEL_MONO, 1'b1);
    queue_random(80);
    drain();

    while (expected_q.size() != 0) begin
      lost = expected_q.pop_front();
      $error("missing result: read_data %02h", lost.rdata);
      fail_count++;
    end
    $display("Checked %0d port accesses (%0d writes, %0d DMA start pulses)",
             results_seen, writes_seen, starts_seen);
    $display("across %0d console model / orientation settings", configs_used);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

endmodule
